>>> rtl/core/imhdk_pkg.sv
`default_nettype none
package imhdk_pkg;

    // default sizes
    localparam int MAX_VERTICES_DEF = 256;
    localparam int KEY_BITS_DEF     = 32;

    // fixed field widths of the channels
    localparam int MODE_W   = 2;
    localparam int VID_W    = 8;
    localparam int NKEY_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 9;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 56;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_BUILD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DELETE   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DECREASE = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ABSENT = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_VERTEX = 8'd1;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_BFILL,
        S_BLOAD,
        S_BLOADW,
        S_SD_L,
        S_SD_R,
        S_SD_C,
        S_DM_ROOT,
        S_DM_LAST,
        S_DM_LASTW,
        S_DK_POS,
        S_DK_SLOT,
        S_DK_CMP,
        S_SU_RD,
        S_SU_CMP,
        S_FIN
    } fsm_state_t;

endpackage
`default_nettype wire

>>> rtl/core/imhdk_level_cell.sv
`default_nettype none
module imhdk_level_cell #(
    parameter int LEVEL        = 0,
    parameter int SW           = 8,
    parameter int KEY_BITS     = 32,
    parameter int MAX_VERTICES = 256
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       rd_en,
    input  wire logic [SW-1:0]              rd_slot,
    input  wire logic                       wr_en,
    input  wire logic [SW-1:0]              wr_slot,
    input  wire logic signed [KEY_BITS-1:0] wr_key,
    input  wire logic [SW-1:0]              wr_vtx,
    input  wire logic signed [KEY_BITS-1:0] chain_key_in,
    input  wire logic [SW-1:0]              chain_vtx_in,
    output logic signed [KEY_BITS-1:0]      chain_key_out,
    output logic [SW-1:0]                   chain_vtx_out
);

    // slots of this level of the tree
    localparam int BASE  = (1 << LEVEL) - 1;
    localparam int SPAN  = 1 << LEVEL;
    localparam int DEPTH = (MAX_VERTICES - BASE < SPAN) ? (MAX_VERTICES - BASE) : SPAN;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic signed [KEY_BITS-1:0] key_mem [DEPTH];
    logic [SW-1:0]              vtx_mem [DEPTH];

    logic                       rd_hit;
    logic                       wr_hit;
    logic [AW-1:0]              rd_addr;
    logic [AW-1:0]              wr_addr;
    logic                       hit_reg;
    logic signed [KEY_BITS-1:0] key_reg;
    logic [SW-1:0]              vtx_reg;

    // address decode for this level
    assign rd_hit  = (32'(rd_slot) >= BASE) && (32'(rd_slot) < BASE + DEPTH);
    assign wr_hit  = (32'(wr_slot) >= BASE) && (32'(wr_slot) < BASE + DEPTH);
    assign rd_addr = AW'(32'(rd_slot) - BASE);
    assign wr_addr = AW'(32'(wr_slot) - BASE);

    // level storage
    always_ff @(posedge aclk) begin
        if (wr_en && wr_hit) begin
            key_mem[wr_addr] <= wr_key;
            vtx_mem[wr_addr] <= wr_vtx;
        end
        if (rd_en && rd_hit) begin
            key_reg <= key_mem[rd_addr];
            vtx_reg <= vtx_mem[rd_addr];
        end
    end

    // which level answered the last read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg <= 1'b0;
        end else if (rd_en) begin
            hit_reg <= rd_hit;
        end
    end

    // read data travels down the row of levels
    assign chain_key_out = hit_reg ? key_reg : chain_key_in;
    assign chain_vtx_out = hit_reg ? vtx_reg : chain_vtx_in;

endmodule
`default_nettype wire

>>> rtl/core/indexed_min_heap_decrease_key.sv
`default_nettype none
// Indexed binary min-heap of vertices with signed keys, with decrease-key.
// Input stream s_*: one transaction per operation (build, delete minimum,
// decrease key). Result stream m_*: exactly one transaction per operation,
// carrying status, removed vertex and key, and the entries left.
// Configuration channel cfg_*: vertex_count (index 0), start_vertex (index 1),
// always ready; the user must write it only while the block is idle, as the
// block itself does not enforce this. Operations run one at a time on a
// sequencer; the heap is stored in a row of level cells, one per tree level,
// each with its own small memory, whose read data passes from cell to cell.
// At most one heap access is made per cycle. Delete minimum reads the root
// and the last entry, then sifts down unless the heap is now empty; on an
// empty heap it goes straight to the result. Decrease key reads the vertex's
// position and slot, then sifts up if the new key is lower; an absent vertex
// goes straight to the result. Build fills n slots, then sifts down each of
// the n/2 inner slots. The next operation can be accepted in the same cycle
// as the result appears, even while that result waits; a stalled receiver
// holds the result and the next operation waits at its end.
// Reset empties the heap and sets vertex_count to 1 and start_vertex to 0;
// heap contents are not cleared and need no clearing pass.
module indexed_min_heap_decrease_key
    import imhdk_pkg::*;
#(
    parameter int MAX_VERTICES = imhdk_pkg::MAX_VERTICES_DEF,
    parameter int KEY_BITS     = imhdk_pkg::KEY_BITS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // mode[1:0], vertex_id[9:2], new_key[41:10]
    input  wire logic [imhdk_pkg::S_DATA_W-1:0]      s_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // status[1:0], min_vertex[9:2], min_key[41:10], heap_count[50:42]
    output logic [imhdk_pkg::M_DATA_W-1:0]           m_tdata,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [imhdk_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [imhdk_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int SW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int NL = CW;
    localparam int LW = SW + 2;
    localparam int WB = (KEY_BITS > 32) ? KEY_BITS : 32;

    localparam logic signed [KEY_BITS-1:0] KEY_MAX = {1'b0, {(KEY_BITS-1){1'b1}}};
    localparam logic signed [KEY_BITS-1:0] KEY_MIN = {1'b1, {(KEY_BITS-1){1'b0}}};
    localparam logic signed [WB-1:0] KEY_MAX_W = WB'(KEY_MAX);
    localparam logic signed [WB-1:0] KEY_MIN_W = WB'(KEY_MIN);
    localparam logic signed [WB-1:0] I32_MAX_W = WB'(64'sd2147483647);
    localparam logic signed [WB-1:0] I32_MIN_W = WB'(-64'sd2147483648);

    fsm_state_t state_reg, state_next;

    logic [MODE_W-1:0]          op_reg, op_next;
    logic [CW-1:0]              size_reg, size_next;
    logic [COUNT_W-1:0]         vcount_reg;
    logic [VID_W-1:0]           start_reg;
    logic [MAX_VERTICES-1:0]    present_reg, present_next;
    logic signed [KEY_BITS-1:0] cur_key_reg, cur_key_next;
    logic [SW-1:0]              cur_vtx_reg, cur_vtx_next;
    logic [SW-1:0]              idx_reg, idx_next;
    logic [CW-1:0]              bidx_reg, bidx_next;
    logic [CW-1:0]              fill_reg, fill_next;
    logic signed [KEY_BITS-1:0] lkey_reg, lkey_next;
    logic [SW-1:0]              lvtx_reg, lvtx_next;
    logic signed [KEY_BITS-1:0] nkey_reg, nkey_next;
    logic [VID_W-1:0]           nvtx_reg, nvtx_next;
    logic [STATUS_W-1:0]        status_reg, status_next;
    logic [SW-1:0]              outv_reg, outv_next;
    logic signed [KEY_BITS-1:0] outk_reg, outk_next;
    logic                       m_valid_reg;
    logic [M_DATA_W-1:0]        m_data_reg;

    // heap port
    logic                       rd_en;
    logic [SW-1:0]              rd_slot;
    logic                       wr_en;
    logic [SW-1:0]              wr_slot;
    logic signed [KEY_BITS-1:0] wr_key;
    logic [SW-1:0]              wr_vtx;
    logic signed [KEY_BITS-1:0] chain_key [NL+1];
    logic [SW-1:0]              chain_vtx [NL+1];
    logic signed [KEY_BITS-1:0] rd_key;
    logic [SW-1:0]              rd_vtx;

    // position map port
    logic [SW-1:0]              pos_mem [MAX_VERTICES];
    logic                       pos_wr_en;
    logic [SW-1:0]              pos_wr_addr;
    logic [SW-1:0]              pos_wr_data;
    logic                       pos_rd_en;
    logic [SW-1:0]              pos_rd_data_reg;

    // input fields
    logic [MODE_W-1:0]          in_mode;
    logic [VID_W-1:0]           in_vid;
    logic signed [NKEY_W-1:0]   in_nkey;
    logic signed [WB-1:0]       in_nkey_w;
    logic signed [KEY_BITS-1:0] in_nkey_sat;
    logic                       accept;
    logic                       vid_in_range;
    logic [SW-1:0]              vid_idx;

    // derived values
    logic [CW-1:0]              n_build;
    logic [LW-1:0]              size_l;
    logic [LW-1:0]              l_slot;
    logic [LW-1:0]              r_slot;
    logic                       l_in;
    logic                       r_in;
    logic [SW-1:0]              par_slot;
    logic                       pick_right;
    logic signed [KEY_BITS-1:0] child_key;
    logic [SW-1:0]              child_vtx;
    logic [SW-1:0]              child_slot;
    logic                       child_wins;
    fsm_state_t                 sd_done_state;
    logic                       out_free;
    logic signed [WB-1:0]       outk_w;
    logic signed [NKEY_W-1:0]   outk_sat;

    assign in_mode   = s_tdata[1:0];
    assign in_vid    = s_tdata[9:2];
    assign in_nkey   = s_tdata[41:10];
    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign out_free  = !m_valid_reg || m_tready;

    // new key clipped to the key range
    assign in_nkey_w = WB'(in_nkey);
    always_comb begin
        if (in_nkey_w > KEY_MAX_W) begin
            in_nkey_sat = KEY_MAX;
        end else if (in_nkey_w < KEY_MIN_W) begin
            in_nkey_sat = KEY_MIN;
        end else begin
            in_nkey_sat = KEY_BITS'(in_nkey_w);
        end
    end

    assign vid_in_range = (32'(in_vid) < MAX_VERTICES);
    assign vid_idx      = SW'(in_vid);

    // build count limited to capacity
    always_comb begin
        if (32'(vcount_reg) >= MAX_VERTICES) begin
            n_build = CW'(MAX_VERTICES);
        end else begin
            n_build = CW'(vcount_reg);
        end
    end

    // tree neighbours of the current slot
    assign size_l     = LW'(size_reg);
    assign l_slot     = (LW'(idx_reg) << 1) + LW'(1);
    assign r_slot     = l_slot + LW'(1);
    assign l_in       = l_slot < size_l;
    assign r_in       = r_slot < size_l;
    assign par_slot   = SW'((idx_reg - SW'(1)) >> 1);
    assign pick_right = r_in && (rd_key < lkey_reg);
    assign child_key  = pick_right ? rd_key : lkey_reg;
    assign child_vtx  = pick_right ? rd_vtx : lvtx_reg;
    assign child_slot = pick_right ? SW'(r_slot) : SW'(l_slot);
    assign child_wins = child_key < cur_key_reg;

    // where a finished sift-down goes
    always_comb begin
        if (op_reg == MODE_BUILD && bidx_reg != CW'(1)) begin
            sd_done_state = S_BLOAD;
        end else begin
            sd_done_state = S_FIN;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    priority if (in_mode == MODE_BUILD) begin
                        state_next = S_BFILL;
                    end else if (in_mode == MODE_DELETE) begin
                        state_next = (size_reg == '0) ? S_FIN : S_DM_ROOT;
                    end else if (in_mode == MODE_DECREASE) begin
                        state_next = (vid_in_range && present_reg[vid_idx]) ? S_DK_POS : S_FIN;
                    end else begin
                        state_next = S_FIN;
                    end
                end
            end
            S_BFILL: begin
                if (fill_reg == n_build) begin
                    state_next = ((n_build >> 1) == '0) ? S_FIN : S_BLOAD;
                end
            end
            S_BLOAD:    state_next = S_BLOADW;
            S_BLOADW:   state_next = S_SD_L;
            S_SD_L:     state_next = l_in ? S_SD_R : sd_done_state;
            S_SD_R:     state_next = S_SD_C;
            S_SD_C:     state_next = child_wins ? S_SD_L : sd_done_state;
            S_DM_ROOT:  state_next = S_DM_LAST;
            S_DM_LAST:  state_next = S_DM_LASTW;
            S_DM_LASTW: state_next = (size_reg == '0) ? S_FIN : S_SD_L;
            S_DK_POS:   state_next = S_DK_SLOT;
            S_DK_SLOT:  state_next = S_DK_CMP;
            S_DK_CMP: begin
                if (LW'(idx_reg) < size_l && nkey_reg < rd_key) begin
                    state_next = S_SU_RD;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_SU_RD:    state_next = (idx_reg == '0) ? S_FIN : S_SU_CMP;
            S_SU_CMP:   state_next = (rd_key > cur_key_reg) ? S_SU_RD : S_FIN;
            S_FIN:      state_next = out_free ? S_IDLE : S_FIN;
            default:    state_next = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        op_next      = op_reg;
        size_next    = size_reg;
        present_next = present_reg;
        cur_key_next = cur_key_reg;
        cur_vtx_next = cur_vtx_reg;
        idx_next     = idx_reg;
        bidx_next    = bidx_reg;
        fill_next    = fill_reg;
        lkey_next    = lkey_reg;
        lvtx_next    = lvtx_reg;
        nkey_next    = nkey_reg;
        nvtx_next    = nvtx_reg;
        status_next  = status_reg;
        outv_next    = outv_reg;
        outk_next    = outk_reg;
        rd_en        = 1'b0;
        rd_slot      = idx_reg;
        wr_en        = 1'b0;
        wr_slot      = idx_reg;
        wr_key       = cur_key_reg;
        wr_vtx       = cur_vtx_reg;
        pos_wr_en    = 1'b0;
        pos_wr_addr  = cur_vtx_reg;
        pos_wr_data  = idx_reg;
        pos_rd_en    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    op_next     = in_mode;
                    nkey_next   = in_nkey_sat;
                    nvtx_next   = in_vid;
                    status_next = STATUS_OK;
                    outv_next   = '0;
                    outk_next   = '0;
                    priority if (in_mode == MODE_BUILD) begin
                        present_next = '0;
                        size_next    = n_build;
                        fill_next    = '0;
                    end else if (in_mode == MODE_DELETE) begin
                        if (size_reg == '0) begin
                            status_next = STATUS_EMPTY;
                        end
                    end else if (in_mode == MODE_DECREASE) begin
                        if (!(vid_in_range && present_reg[vid_idx])) begin
                            status_next = STATUS_ABSENT;
                        end
                    end else begin
                        status_next = STATUS_OK;
                    end
                end
            end
            // load vertices in slot order
            S_BFILL: begin
                if (fill_reg == n_build) begin
                    bidx_next = n_build >> 1;
                end else begin
                    wr_en   = 1'b1;
                    wr_slot = SW'(fill_reg);
                    wr_vtx  = SW'(fill_reg);
                    wr_key  = (CW'(start_reg) == fill_reg && 32'(start_reg) < MAX_VERTICES)
                              ? '0 : KEY_MAX;
                    pos_wr_en   = 1'b1;
                    pos_wr_addr = SW'(fill_reg);
                    pos_wr_data = SW'(fill_reg);
                    present_next[SW'(fill_reg)] = 1'b1;
                    fill_next = fill_reg + CW'(1);
                end
            end
            // fetch next slot to heapify
            S_BLOAD: begin
                rd_en   = 1'b1;
                rd_slot = SW'(bidx_reg - CW'(1));
            end
            S_BLOADW: begin
                cur_key_next = rd_key;
                cur_vtx_next = rd_vtx;
                idx_next     = SW'(bidx_reg - CW'(1));
            end
            // sift down
            S_SD_L: begin
                if (l_in) begin
                    rd_en   = 1'b1;
                    rd_slot = SW'(l_slot);
                end else begin
                    wr_en     = 1'b1;
                    pos_wr_en = 1'b1;
                    if (op_reg == MODE_BUILD) begin
                        bidx_next = bidx_reg - CW'(1);
                    end
                end
            end
            S_SD_R: begin
                lkey_next = rd_key;
                lvtx_next = rd_vtx;
                if (r_in) begin
                    rd_en   = 1'b1;
                    rd_slot = SW'(r_slot);
                end
            end
            S_SD_C: begin
                wr_en     = 1'b1;
                pos_wr_en = 1'b1;
                if (child_wins) begin
                    wr_key      = child_key;
                    wr_vtx      = child_vtx;
                    pos_wr_addr = child_vtx;
                    idx_next    = child_slot;
                end else if (op_reg == MODE_BUILD) begin
                    bidx_next = bidx_reg - CW'(1);
                end
            end
            // delete minimum
            S_DM_ROOT: begin
                rd_en   = 1'b1;
                rd_slot = '0;
            end
            S_DM_LAST: begin
                outv_next = rd_vtx;
                outk_next = rd_key;
                present_next[rd_vtx] = 1'b0;
                size_next = size_reg - CW'(1);
                rd_en     = 1'b1;
                rd_slot   = SW'(size_reg - CW'(1));
            end
            S_DM_LASTW: begin
                cur_key_next = rd_key;
                cur_vtx_next = rd_vtx;
                idx_next     = '0;
            end
            // decrease key
            S_DK_POS: begin
                pos_rd_en = 1'b1;
            end
            S_DK_SLOT: begin
                rd_en    = 1'b1;
                rd_slot  = pos_rd_data_reg;
                idx_next = pos_rd_data_reg;
            end
            S_DK_CMP: begin
                cur_key_next = nkey_reg;
                cur_vtx_next = SW'(nvtx_reg);
            end
            // sift up
            S_SU_RD: begin
                if (idx_reg == '0) begin
                    wr_en     = 1'b1;
                    pos_wr_en = 1'b1;
                end else begin
                    rd_en   = 1'b1;
                    rd_slot = par_slot;
                end
            end
            S_SU_CMP: begin
                wr_en     = 1'b1;
                pos_wr_en = 1'b1;
                if (rd_key > cur_key_reg) begin
                    wr_key      = rd_key;
                    wr_vtx      = rd_vtx;
                    pos_wr_addr = rd_vtx;
                    idx_next    = par_slot;
                end
            end
            S_FIN: begin
            end
            default: begin
            end
        endcase
    end

    // heap levels, read data chained from root level downward
    assign chain_key[0] = '0;
    assign chain_vtx[0] = '0;
    for (genvar lv = 0; lv < NL; lv++) begin : g_level
        imhdk_level_cell #(
            .LEVEL        (lv),
            .SW           (SW),
            .KEY_BITS     (KEY_BITS),
            .MAX_VERTICES (MAX_VERTICES)
        ) u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .rd_en         (rd_en),
            .rd_slot       (rd_slot),
            .wr_en         (wr_en),
            .wr_slot       (wr_slot),
            .wr_key        (wr_key),
            .wr_vtx        (wr_vtx),
            .chain_key_in  (chain_key[lv]),
            .chain_vtx_in  (chain_vtx[lv]),
            .chain_key_out (chain_key[lv+1]),
            .chain_vtx_out (chain_vtx[lv+1])
        );
    end
    assign rd_key = chain_key[NL];
    assign rd_vtx = chain_vtx[NL];

    // position map
    always_ff @(posedge aclk) begin
        if (pos_wr_en) begin
            pos_mem[pos_wr_addr] <= pos_wr_data;
        end
        if (pos_rd_en) begin
            pos_rd_data_reg <= pos_mem[SW'(nvtx_reg)];
        end
    end

    // removed key clipped to 32 bits
    assign outk_w = WB'(outk_reg);
    always_comb begin
        if (outk_w > I32_MAX_W) begin
            outk_sat = NKEY_W'(I32_MAX_W);
        end else if (outk_w < I32_MIN_W) begin
            outk_sat = NKEY_W'(I32_MIN_W);
        end else begin
            outk_sat = NKEY_W'(outk_w);
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            size_reg    <= '0;
            present_reg <= '0;
            vcount_reg  <= COUNT_W'(1);
            start_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            size_reg    <= size_next;
            present_reg <= present_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_VERTEX_COUNT) begin
                    vcount_reg <= cfg_data[COUNT_W-1:0];
                end else if (cfg_index == REG_START_VERTEX) begin
                    start_reg <= cfg_data[VID_W-1:0];
                end
            end
            if (state_reg == S_FIN && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        cur_key_reg <= cur_key_next;
        cur_vtx_reg <= cur_vtx_next;
        idx_reg     <= idx_next;
        bidx_reg    <= bidx_next;
        fill_reg    <= fill_next;
        lkey_reg    <= lkey_next;
        lvtx_reg    <= lvtx_next;
        nkey_reg    <= nkey_next;
        nvtx_reg    <= nvtx_next;
        status_reg  <= status_next;
        outv_reg    <= outv_next;
        outk_reg    <= outk_next;
        if (state_reg == S_FIN && out_free) begin
            m_data_reg <= {5'd0, COUNT_W'(size_reg), outk_sat, VID_W'(outv_reg), status_reg};
        end
    end

`ifndef SYNTHESIS
    a_size_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(size_reg) <= MAX_VERTICES)
        else $error("heap size beyond capacity");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("operation accepted while another runs");

    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[1:0] == STATUS_EMPTY) |-> (m_tdata[50:42] == '0))
        else $error("empty status with entries left");

    a_fin_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FIN && m_tvalid && !m_tready) |=> (state_reg == S_FIN))
        else $error("result overwritten while stalled");
`endif

endmodule
`default_nettype wire

>>> test/indexed_min_heap_decrease_key_tb.sv
`default_nettype none
module indexed_min_heap_decrease_key_tb;
    import imhdk_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NV = 256;
    localparam logic signed [31:0] KEY_TOP = 32'sh7fffffff;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] vertex;
        logic signed [31:0] key;
        logic [8:0] count;
    } heap_result_t;

    // one row of the directed table; typed_in marks a hand-written result
    typedef struct {
        logic [1:0] mode;
        logic [7:0] vid;
        logic signed [31:0] nkey;
        bit typed_in;
        heap_result_t res;
    } op_row_t;

    always #4 aclk = ~aclk;

    indexed_min_heap_decrease_key dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // shadow heap
    logic signed [31:0] sh_key [NV];
    logic [7:0] sh_vert [NV];
    logic [7:0] sh_pos [NV];
    bit sh_here [NV];
    int sh_size;
    int sh_count_reg;
    int sh_start;

    heap_result_t pending_results[$];
    int mismatches;

    function automatic void swap_slots(int a, int b);
        logic signed [31:0] k;
        logic [7:0] v;
        k = sh_key[a]; v = sh_vert[a];
        sh_key[a] = sh_key[b]; sh_vert[a] = sh_vert[b];
        sh_key[b] = k; sh_vert[b] = v;
        sh_pos[sh_vert[a]] = a[7:0];
        sh_pos[sh_vert[b]] = b[7:0];
    endfunction

    function automatic void sink(int i);
        int l, c;
        forever begin
            l = 2 * i + 1;
            if (l >= sh_size) return;
            c = l;
            if (l + 1 < sh_size && sh_key[l+1] < sh_key[l]) c = l + 1;
            if (sh_key[c] >= sh_key[i]) return;
            swap_slots(i, c);
            i = c;
        end
    endfunction

    function automatic void rise(int i);
        int p;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (sh_key[p] <= sh_key[i]) return;
            swap_slots(i, p);
            i = p;
        end
    endfunction

    // apply one operation to the shadow heap and return its result
    function automatic heap_result_t apply_op(logic [1:0] mode, logic [7:0] vid,
                                              logic signed [31:0] nkey);
        heap_result_t r;
        int n, p;
        r = '0;
        case (mode)
            MODE_BUILD: begin
                n = (sh_count_reg > NV) ? NV : sh_count_reg;
                for (int i = 0; i < NV; i++) sh_here[i] = 1'b0;
                for (int i = 0; i < n; i++) begin
                    sh_key[i] = KEY_TOP; sh_vert[i] = i[7:0];
                    sh_pos[i] = i[7:0]; sh_here[i] = 1'b1;
                end
                sh_size = n;
                if (sh_start < n) sh_key[sh_start] = 0;
                for (int i = n / 2; i > 0; i--) sink(i - 1);
            end
            MODE_DELETE: begin
                if (sh_size == 0) begin
                    r.status = STATUS_EMPTY;
                end else begin
                    r.vertex = sh_vert[0];
                    r.key = sh_key[0];
                    sh_here[sh_vert[0]] = 1'b0;
                    sh_size--;
                    if (sh_size > 0) begin
                        sh_key[0] = sh_key[sh_size];
                        sh_vert[0] = sh_vert[sh_size];
                        sh_pos[sh_vert[0]] = 8'd0;
                        sink(0);
                    end
                end
            end
            MODE_DECREASE: begin
                if (!sh_here[vid]) begin
                    r.status = STATUS_ABSENT;
                end else begin
                    p = sh_pos[vid];
                    if (p < sh_size && nkey < sh_key[p]) begin
                        sh_key[p] = nkey;
                        rise(p);
                    end
                end
            end
            default: ;
        endcase
        r.count = sh_size[8:0];
        return r;
    endfunction

    task automatic send_op(logic [1:0] mode, logic [7:0] vid, logic signed [31:0] nkey,
                           bit typed_in, heap_result_t typed_res);
        heap_result_t r;
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata <= {6'd0, nkey, vid, mode};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = apply_op(mode, vid, nkey);
        if (typed_in && r !== typed_res) begin
            mismatches++;
            if (mismatches <= 10)
                $display("table row disagrees with shadow heap: typed %h shadow %h",
                         typed_res, r);
        end
        pending_results.insert(pending_results.size(), typed_in ? typed_res : r);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        cfg_index <= idx;
        cfg_data <= value[CFG_DATA_W-1:0];
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        if (idx == REG_VERTEX_COUNT) sh_count_reg = value & 'h1ff;
        else sh_start = value & 'hff;
    endtask

    // result checking against the oldest expectation
    always @(posedge aclk) begin
        heap_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[50:42], m_tdata[41:10], m_tdata[9:2], m_tdata[1:0]} ;
            got.status = m_tdata[1:0];
            got.vertex = m_tdata[9:2];
            got.key = m_tdata[41:10];
            got.count = m_tdata[50:42];
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", m_tdata);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result mismatch: status %0d/%0d vertex %0d/%0d",
                                  " key %0d/%0d count %0d/%0d"},
                                 want.status, got.status, want.vertex, got.vertex,
                                 want.key, got.key, want.count, got.count);
                end
            end
        end
    end

    // receiver stalls
    initial begin
        int stall;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
                if (stall != 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
                m_tready <= 1'b1;
            end else if (!m_tready) begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

    op_row_t table_rows[$];

    function automatic op_row_t row(logic [1:0] m, logic [7:0] v, logic signed [31:0] k,
                                    bit t, logic [1:0] st, logic [7:0] rv,
                                    logic signed [31:0] rk, int c);
        op_row_t o;
        o.mode = m; o.vid = v; o.nkey = k; o.typed_in = t;
        o.res.status = st; o.res.vertex = rv; o.res.key = rk; o.res.count = c[8:0];
        return o;
    endfunction

    initial begin
        int ops, v, k, wr;
        logic [1:0] m;
        mismatches = 0;
        sh_size = 0; sh_count_reg = 1; sh_start = 0;
        for (int i = 0; i < NV; i++) begin
            sh_here[i] = 1'b0; sh_key[i] = 0; sh_vert[i] = 0; sh_pos[i] = 0;
        end
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed after reset: empty delete, absent id, unused mode, 1-vertex heap
        table_rows.insert(table_rows.size(),
                          row(MODE_DELETE, 8'd0, 0, 1, STATUS_EMPTY, 0, 0, 0));
        table_rows.insert(table_rows.size(),
                          row(MODE_DECREASE, 8'd255, -5, 1, STATUS_ABSENT, 0, 0, 0));
        table_rows.insert(table_rows.size(),
                          row(2'd3, 8'hff, -1, 1, STATUS_OK, 0, 0, 0));
        table_rows.insert(table_rows.size(),
                          row(MODE_BUILD, 0, 0, 1, STATUS_OK, 0, 0, 1));
        table_rows.insert(table_rows.size(),
                          row(MODE_DECREASE, 8'd0, 32'sh80000000, 1, STATUS_OK, 0, 0, 1));
        table_rows.insert(table_rows.size(),
                          row(MODE_DECREASE, 8'd0, KEY_TOP, 1, STATUS_OK, 0, 0, 1));
        table_rows.insert(table_rows.size(),
                          row(MODE_DELETE, 0, 0, 1, STATUS_OK, 0, 32'sh80000000, 0));
        table_rows.insert(table_rows.size(),
                          row(MODE_DELETE, 0, 0, 1, STATUS_EMPTY, 0, 0, 0));
        table_rows.insert(table_rows.size(),
                          row(MODE_DECREASE, 8'd0, 1, 1, STATUS_ABSENT, 0, 0, 0));
        foreach (table_rows[i])
            send_op(table_rows[i].mode, table_rows[i].vid, table_rows[i].nkey,
                    table_rows[i].typed_in, table_rows[i].res);
        drain();

        // full size with start at the top vertex
        write_reg(REG_VERTEX_COUNT, 256);
        write_reg(REG_START_VERTEX, 255);
        send_op(MODE_BUILD, 0, 0, 0, '0);
        send_op(MODE_DECREASE, 8'd128, -1, 0, '0);
        send_op(MODE_DECREASE, 8'd7, 32'sh80000000, 0, '0);
        send_op(MODE_DECREASE, 8'd9, 32'sh7ffffffe, 0, '0);
        send_op(MODE_DELETE, 0, 0, 0, '0);
        send_op(MODE_DELETE, 0, 0, 0, '0);
        send_op(MODE_DECREASE, 8'd7, 5, 1, row(0,0,0,1,STATUS_ABSENT,0,0,254).res);
        drain();

        // oversized count saturates, start outside count, empty build
        write_reg(REG_VERTEX_COUNT, 511);
        send_op(MODE_BUILD, 0, 0, 1, row(0,0,0,1,STATUS_OK,0,0,256).res);
        drain();
        write_reg(REG_VERTEX_COUNT, 4);
        write_reg(REG_START_VERTEX, 200);
        send_op(MODE_BUILD, 0, 0, 1, row(0,0,0,1,STATUS_OK,0,0,4).res);
        send_op(MODE_DELETE, 0, 0, 1, row(0,0,0,1,STATUS_OK,0,KEY_TOP,3).res);
        drain();
        write_reg(REG_VERTEX_COUNT, 0);
        send_op(MODE_BUILD, 0, 0, 1, row(0,0,0,1,STATUS_OK,0,0,0).res);
        send_op(MODE_DELETE, 0, 0, 1, row(0,0,0,1,STATUS_EMPTY,0,0,0).res);
        drain();

        // random phases: build, then mostly decreases and deletes on present vertices
        ops = 0;
        while (ops < 500) begin
            wr = $urandom_range(0, 7);
            write_reg(REG_VERTEX_COUNT, (wr == 0) ? 256 : (wr == 1) ? 1 :
                      (wr == 2) ? $urandom_range(257, 511) : $urandom_range(2, 40));
            write_reg(REG_START_VERTEX, ($urandom_range(0, 3) == 0) ?
                      $urandom_range(0, 255) : $urandom_range(0, 40));
            send_op(MODE_BUILD, $urandom, $urandom, 0, '0);
            ops++;
            repeat ($urandom_range(20, 60)) begin
                m = ($urandom_range(0, 9) < 6) ? MODE_DECREASE :
                    ($urandom_range(0, 9) == 0) ? 2'd3 : MODE_DELETE;
                v = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) :
                    $urandom_range(0, (sh_count_reg > 1) ? ((sh_count_reg > 256) ? 255 :
                                   sh_count_reg - 1) : 0);
                case ($urandom_range(0, 3))
                    0: k = $urandom;
                    1: k = $urandom_range(0, 1) ? 32'sh80000000 : KEY_TOP;
                    default: k = $signed($urandom_range(0, 2000)) - 1000;
                endcase
                send_op(m, v[7:0], k, 0, '0);
                ops++;
            end
            drain();
        end

        // final wait, then verdict
        drain();
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
`default_nettype wire

>>> files.f
rtl/core/imhdk_pkg.sv
rtl/core/imhdk_level_cell.sv
rtl/core/indexed_min_heap_decrease_key.sv
test/indexed_min_heap_decrease_key_tb.sv
